// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; sme_exec.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sme_pkg.sv =====
package sme_pkg;

    localparam int DATA_DEPTH_DEF = 64;
    localparam int CALL_DEPTH_DEF = 16;
    localparam int LOCALS_PER_FRAME_DEF = 16;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_POP   = 5'd1,
        OP_ADD   = 5'd2,
        OP_SUB   = 5'd3,
        OP_MUL   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_NOT   = 5'd7,
        OP_LT    = 5'd8,
        OP_EQ    = 5'd9,
        OP_JMP   = 5'd10,
        OP_JZ    = 5'd11,
        OP_LOAD  = 5'd12,
        OP_STORE = 5'd13,
        OP_CALL  = 5'd14,
        OP_RET   = 5'd15,
        OP_PRINT = 5'd16,
        OP_HALT  = 5'd17
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_OP    = 3'd1,
        ERR_DATA  = 3'd2,
        ERR_CALL  = 3'd3,
        ERR_LOCAL = 3'd4
    } err_t;

    typedef struct packed {
        logic        restart;
        logic        bad;
        op_t         op;
        logic [31:0] opnd;
        logic [4:0]  nargs;
    } dec_t;

    typedef struct packed {
        logic [15:0] next_address;
        logic        print_valid;
        logic [31:0] print_value;
        logic        halted;
        err_t        error_code;
    } res_t;

endpackage

// ===== rtl/stack_machine_execute.sv =====
// A beat waits in the input queue; the sequencer reads the stack in S_IDLE, executes it in
// S_EXEC and writes the result to the result queue, from which it can be popped.
// S_IDLE waits while the result queue is full. A call adds an S_CRD data stack read and an
// S_CWR locals write per copied argument.
// Reset clears all control state; a clearing pass then zeroes the locals memory, all
// CALL_DEPTH * LOCALS_PER_FRAME words, one word a cycle, during which full stays high.
module stack_machine_execute #(
    parameter int DATA_DEPTH       = sme_pkg::DATA_DEPTH_DEF,
    parameter int CALL_DEPTH       = sme_pkg::CALL_DEPTH_DEF,
    parameter int LOCALS_PER_FRAME = sme_pkg::LOCALS_PER_FRAME_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic               action,
    input  logic [4:0]         op_code,
    input  logic signed [31:0] first_operand,
    input  logic [4:0]         arg_count,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        next_address,
    output logic               print_valid,
    output logic signed [31:0] print_value,
    output logic               halted,
    output logic [2:0]         error_code
);

    logic [15:0]   start_reg, len_reg;
    logic          q_valid, q_pop, clearing, oq_full, emit;
    sme_pkg::dec_t q_head;
    sme_pkg::res_t res, head;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, len_reg} : {16'd0, start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 16'd0;
            len_reg   <= 16'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                len_reg <= pwdata[15:0];
            end
            else
            begin
                start_reg <= pwdata[15:0];
            end
        end
    end

    sme_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .op_code       (op_code),
        .first_operand (first_operand),
        .arg_count     (arg_count),
        .clearing      (clearing),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    sme_exec #(
        .DATA_DEPTH       (DATA_DEPTH),
        .CALL_DEPTH       (CALL_DEPTH),
        .LOCALS_PER_FRAME (LOCALS_PER_FRAME)
    ) u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_address  (start_reg),
        .program_length (len_reg),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .oq_full        (oq_full),
        .emit           (emit),
        .res            (res)
    );

    sme_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (emit),
        .wr_data (res),
        .oq_full (oq_full),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign next_address = head.next_address;
    assign print_valid  = head.print_valid;
    assign print_value  = $signed(head.print_value);
    assign halted       = head.halted;
    assign error_code   = head.error_code;

endmodule

// ===== rtl/sme_front.sv =====
module sme_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              action,
    input  logic [4:0]        op_code,
    input  logic signed [31:0] first_operand,
    input  logic [4:0]        arg_count,
    input  logic              clearing,
    output logic              q_valid,
    output sme_pkg::dec_t     q_head,
    input  logic              q_pop
);

    sme_pkg::dec_t ent_reg [2];
    sme_pkg::dec_t dec;
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push;

    always_comb
    begin
        dec.restart = ~action;
        dec.bad     = (op_code > sme_pkg::OP_HALT);
        dec.op      = sme_pkg::op_t'(op_code);
        dec.opnd    = $unsigned(first_operand);
        dec.nargs   = arg_count;
    end

    assign full    = (cnt_reg == 2'd2) | clearing;
    assign do_push = push & ~full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ (q_pop & q_valid);
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, q_pop & q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= dec;
        end
    end

endmodule

// ===== rtl/sme_outq.sv =====
module sme_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  sme_pkg::res_t wr_data,
    output logic          oq_full,
    output logic          empty,
    input  logic          pop,
    output sme_pkg::res_t head
);

    sme_pkg::res_t ent_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          do_wr, do_rd;

    assign oq_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr & ~oq_full;
    assign do_rd   = pop & ~empty;
    assign head    = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_reg ^ do_wr;
            rp_reg  <= rp_reg ^ do_rd;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            ent_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/sme_exec.sv =====
`include "assert_macros.svh"

module sme_exec #(
    parameter int DATA_DEPTH       = sme_pkg::DATA_DEPTH_DEF,
    parameter int CALL_DEPTH       = sme_pkg::CALL_DEPTH_DEF,
    parameter int LOCALS_PER_FRAME = sme_pkg::LOCALS_PER_FRAME_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   start_address,
    input  logic [15:0]   program_length,
    input  logic          q_valid,
    input  sme_pkg::dec_t q_head,
    output logic          q_pop,
    output logic          clearing,
    input  logic          oq_full,
    output logic          emit,
    output sme_pkg::res_t res
);

    localparam int DW  = $clog2(DATA_DEPTH + 1);
    localparam int DIW = $clog2(DATA_DEPTH);
    localparam int FW  = $clog2(CALL_DEPTH + 1);
    localparam int FIW = $clog2(CALL_DEPTH);
    localparam int LW  = CALL_DEPTH * LOCALS_PER_FRAME;
    localparam int LAW = $clog2(LW);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_CRD, S_CWR} state_t;

    state_t          state_reg, state_next;
    logic [DW-1:0]   n_reg, n_next;
    logic [FW-1:0]   fi_reg, fi_next;
    logic [15:0]     ip_reg, ip_next;
    logic            stop_reg, stop_next;
    sme_pkg::err_t   err_reg, err_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [LAW-1:0]  clr_reg, clr_next;

    logic [31:0]     ds_mem [DATA_DEPTH];
    logic [31:0]     lw_mem [LW];
    logic [15:0]     rs_reg [CALL_DEPTH];
    logic [31:0]     rda_reg, rdb_reg, rdl_reg;

    logic            ds_we, lw_we, rs_we;
    logic [DIW-1:0]  ds_wa, ra, rb;
    logic [31:0]     ds_wd, lw_wd;
    logic [LAW-1:0]  lw_wa, rl;
    logic [16:0]     nxt;
    logic            fin, fail, halt_op, do_call, call_done, pv;
    sme_pkg::err_t   fcode;
    logic [31:0]     a, b, pval;

    assign clearing = (state_reg == S_CLEAR);
    assign a = rdb_reg;
    assign b = rda_reg;
    assign rb = DIW'(n_reg - DW'(2));
    assign rl = LAW'(32'(fi_reg - FW'(1)) * 32'(LOCALS_PER_FRAME) + q_head.opnd);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        fi_next    = fi_reg;
        ip_next    = ip_reg;
        stop_next  = stop_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        ds_we      = 1'b0;
        ds_wa      = DIW'(n_reg);
        ds_wd      = q_head.opnd;
        lw_we      = 1'b0;
        lw_wa      = rl;
        lw_wd      = b;
        rs_we      = 1'b0;
        ra         = DIW'(n_reg - DW'(1));
        emit       = 1'b0;
        q_pop      = 1'b0;
        pv         = 1'b0;
        pval       = 32'd0;
        fin        = 1'b0;
        fail       = 1'b0;
        fcode      = sme_pkg::ERR_NONE;
        halt_op    = 1'b0;
        do_call    = 1'b0;
        call_done  = 1'b0;
        nxt        = {1'b0, ip_reg} + 17'd1;
        unique case (state_reg)
            S_CLEAR:
            begin
                lw_we    = 1'b1;
                lw_wa    = clr_reg;
                lw_wd    = 32'd0;
                clr_next = clr_reg + LAW'(1);
                if (clr_reg == LAW'(LW - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !oq_full)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (q_head.restart)
                begin
                    ip_next   = start_address;
                    n_next    = '0;
                    fi_next   = '0;
                    err_next  = sme_pkg::ERR_NONE;
                    stop_next = (start_address >= program_length);
                    emit      = 1'b1;
                    q_pop     = 1'b1;
                end
                else if (stop_reg)
                begin
                    emit  = 1'b1;
                    q_pop = 1'b1;
                end
                else if (ip_reg >= program_length)
                begin
                    stop_next = 1'b1;
                    emit      = 1'b1;
                    q_pop     = 1'b1;
                end
                else
                begin
                    if (q_head.bad)
                    begin
                        fail  = 1'b1;
                        fcode = sme_pkg::ERR_OP;
                    end
                    else
                    begin
                        unique case (q_head.op)
                            sme_pkg::OP_PUSH:
                            begin
                                if (32'(n_reg) >= 32'(DATA_DEPTH))
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    ds_we  = 1'b1;
                                    n_next = n_reg + DW'(1);
                                    nxt    = {1'b0, ip_reg} + 17'd2;
                                end
                            end
                            sme_pkg::OP_POP:
                            begin
                                if (n_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    n_next = n_reg - DW'(1);
                                end
                            end
                            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                            sme_pkg::OP_AND, sme_pkg::OP_OR, sme_pkg::OP_LT,
                            sme_pkg::OP_EQ:
                            begin
                                if (n_reg < DW'(2))
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    ds_we  = 1'b1;
                                    ds_wa  = rb;
                                    n_next = n_reg - DW'(1);
                                    priority case (q_head.op)
                                        sme_pkg::OP_ADD: ds_wd = a + b;
                                        sme_pkg::OP_SUB: ds_wd = a - b;
                                        sme_pkg::OP_MUL: ds_wd = a * b;
                                        sme_pkg::OP_AND: ds_wd = a & b;
                                        sme_pkg::OP_OR:  ds_wd = a | b;
                                        sme_pkg::OP_LT:
                                            ds_wd = {31'd0, $signed(a) < $signed(b)};
                                        default: ds_wd = {31'd0, a == b};
                                    endcase
                                end
                            end
                            sme_pkg::OP_NOT:
                            begin
                                if (n_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    ds_we = 1'b1;
                                    ds_wa = ra;
                                    ds_wd = {31'd0, b == 32'd0};
                                end
                            end
                            sme_pkg::OP_JMP:
                            begin
                                nxt = {1'b0, q_head.opnd[15:0]};
                            end
                            sme_pkg::OP_JZ:
                            begin
                                if (n_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    n_next = n_reg - DW'(1);
                                    nxt = (b == 32'd0) ? {1'b0, q_head.opnd[15:0]}
                                                       : {1'b0, ip_reg} + 17'd2;
                                end
                            end
                            sme_pkg::OP_LOAD, sme_pkg::OP_STORE:
                            begin
                                nxt = {1'b0, ip_reg} + 17'd2;
                                if (fi_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_CALL;
                                end
                                else if (q_head.opnd >= 32'(LOCALS_PER_FRAME))
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_LOCAL;
                                end
                                else if (q_head.op == sme_pkg::OP_LOAD)
                                begin
                                    if (32'(n_reg) >= 32'(DATA_DEPTH))
                                    begin
                                        fail = 1'b1;
                                        fcode = sme_pkg::ERR_DATA;
                                    end
                                    else
                                    begin
                                        ds_we  = 1'b1;
                                        ds_wd  = rdl_reg;
                                        n_next = n_reg + DW'(1);
                                    end
                                end
                                else if (n_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    lw_we  = 1'b1;
                                    n_next = n_reg - DW'(1);
                                end
                            end
                            sme_pkg::OP_CALL:
                            begin
                                if (32'(fi_reg) >= 32'(CALL_DEPTH))
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_CALL;
                                end
                                else if (32'(q_head.nargs) > 32'(LOCALS_PER_FRAME))
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_LOCAL;
                                end
                                else if (32'(q_head.nargs) > 32'(n_reg))
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    do_call = 1'b1;
                                end
                            end
                            sme_pkg::OP_RET:
                            begin
                                if (fi_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_CALL;
                                end
                                else
                                begin
                                    fi_next = fi_reg - FW'(1);
                                    nxt = {1'b0, rs_reg[FIW'(fi_reg - FW'(1))]};
                                end
                            end
                            sme_pkg::OP_PRINT:
                            begin
                                if (n_reg == '0)
                                begin
                                    fail = 1'b1;
                                    fcode = sme_pkg::ERR_DATA;
                                end
                                else
                                begin
                                    pv     = 1'b1;
                                    pval   = b;
                                    n_next = n_reg - DW'(1);
                                end
                            end
                            sme_pkg::OP_HALT:
                            begin
                                halt_op = 1'b1;
                            end
                            default:
                            begin
                                fail = 1'b1;
                                fcode = sme_pkg::ERR_OP;
                            end
                        endcase
                    end
                    if (fail)
                    begin
                        ds_we     = 1'b0;
                        lw_we     = 1'b0;
                        n_next    = n_reg;
                        fi_next   = fi_reg;
                        pv        = 1'b0;
                        pval      = 32'd0;
                        stop_next = 1'b1;
                        err_next  = fcode;
                        emit      = 1'b1;
                        q_pop     = 1'b1;
                    end
                    else if (do_call)
                    begin
                        cnt_next = 5'd0;
                        if (q_head.nargs == 5'd0)
                        begin
                            call_done = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CRD;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            S_CRD:
            begin
                ra = DIW'(n_reg - DW'(q_head.nargs) + DW'(cnt_reg));
                state_next = S_CWR;
            end
            S_CWR:
            begin
                lw_we    = 1'b1;
                lw_wa    = LAW'(32'(fi_reg) * 32'(LOCALS_PER_FRAME) + 32'(cnt_reg));
                lw_wd    = rda_reg;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg + 5'd1 == q_head.nargs)
                begin
                    call_done  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (call_done)
        begin
            rs_we   = 1'b1;
            n_next  = n_reg - DW'(q_head.nargs);
            fi_next = fi_reg + FW'(1);
            nxt     = {1'b0, q_head.opnd[15:0]};
            fin     = 1'b1;
        end
        if (fin)
        begin
            ip_next   = nxt[15:0];
            stop_next = halt_op | (nxt >= {1'b0, program_length});
            emit      = 1'b1;
            q_pop     = 1'b1;
        end
    end

    always_comb
    begin
        res.next_address = ip_next;
        res.print_valid  = pv;
        res.print_value  = pval;
        res.halted       = stop_next;
        res.error_code   = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            n_reg     <= '0;
            fi_reg    <= '0;
            ip_reg    <= 16'd0;
            stop_reg  <= 1'b0;
            err_reg   <= sme_pkg::ERR_NONE;
            cnt_reg   <= 5'd0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            fi_reg    <= fi_next;
            ip_reg    <= ip_next;
            stop_reg  <= stop_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ds_we)
        begin
            ds_mem[ds_wa] <= ds_wd;
        end
        rda_reg <= ds_mem[ra];
        rdb_reg <= ds_mem[rb];
    end

    always_ff @(posedge clk)
    begin
        if (lw_we)
        begin
            lw_mem[lw_wa] <= lw_wd;
        end
        rdl_reg <= lw_mem[rl];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_reg[FIW'(fi_reg)] <= ip_reg + 16'd4;
        end
    end

    `ASSERT_IMP(a_n_bound, clk, rst_n, 1'b1, 32'(n_reg) <= 32'(DATA_DEPTH))
    `ASSERT_IMP(a_fi_bound, clk, rst_n, 1'b1, 32'(fi_reg) <= 32'(CALL_DEPTH))
    `ASSERT_IMP(a_emit_room, clk, rst_n, emit, !oq_full)
    `ASSERT_IMP(a_err_halts, clk, rst_n, err_reg != sme_pkg::ERR_NONE, stop_reg)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int DDEPTH = sme_pkg::DATA_DEPTH_DEF;
    localparam int CDEPTH = sme_pkg::CALL_DEPTH_DEF;
    localparam int LPF = sme_pkg::LOCALS_PER_FRAME_DEF;
    localparam logic [2:0] ADDR_START = 3'd0;
    localparam logic [2:0] ADDR_LENGTH = 3'd4;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        action;
        logic [4:0]  op_code;
        logic [31:0] first_operand;
        logic [4:0]  arg_count;
    } instr_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic action = 1'b0;
    logic [4:0] op_code = '0;
    logic signed [31:0] first_operand = '0;
    logic [4:0] arg_count = '0;
    logic empty;
    logic pop = 1'b0;
    logic [15:0] next_address;
    logic print_valid;
    logic signed [31:0] print_value;
    logic halted;
    logic [2:0] error_code;

    stack_machine_execute i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .action(action), .op_code(op_code),
        .first_operand(first_operand), .arg_count(arg_count), .empty(empty),
        .pop(pop), .next_address(next_address), .print_valid(print_valid),
        .print_value(print_value), .halted(halted), .error_code(error_code)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Machine state mirrored for prediction.
    logic [31:0] dstack [DDEPTH];
    int unsigned dcount;
    logic [15:0] rstack [CDEPTH];
    int unsigned fcount;
    logic [31:0] locals [CDEPTH * LPF];
    logic [15:0] ip;
    logic stopped;
    sme_pkg::err_t err_held;
    logic [15:0] start_reg;
    logic [15:0] length_reg;

    instr_t pending_instrs [$];
    sme_pkg::res_t expected_results [$];
    int send_idle_pct;
    int recv_idle_pct;
    bit send_hold;
    int mismatches;
    int beats_in;
    int beats_out;
    int prints_seen;
    int errors_seen;
    int idle_cycles;

    function automatic sme_pkg::res_t make_result(logic pv, logic [31:0] val);
        sme_pkg::res_t r;
        r.next_address = ip;
        r.print_valid = pv;
        r.print_value = pv ? val : 32'd0;
        r.halted = stopped;
        r.error_code = err_held;
        return r;
    endfunction

    function automatic sme_pkg::res_t trap(sme_pkg::err_t code);
        err_held = code;
        stopped = 1'b1;
        return make_result(1'b0, 32'd0);
    endfunction

    function automatic sme_pkg::res_t execute_instr(instr_t it);
        logic [16:0] nxt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic pv;
        logic [31:0] val;
        int unsigned base;
        sme_pkg::op_t op;
        pv = 1'b0;
        val = '0;
        if (!it.action)
        begin
            ip = start_reg;
            dcount = 0;
            fcount = 0;
            err_held = sme_pkg::ERR_NONE;
            stopped = (ip >= length_reg);
            return make_result(1'b0, 32'd0);
        end
        if (stopped)
            return make_result(1'b0, 32'd0);
        if (ip >= length_reg)
        begin
            stopped = 1'b1;
            return make_result(1'b0, 32'd0);
        end
        if (it.op_code > sme_pkg::OP_HALT)
            return trap(sme_pkg::ERR_OP);
        op = sme_pkg::op_t'(it.op_code);
        nxt = {1'b0, ip} + 17'd1;
        case (op)
            sme_pkg::OP_PUSH:
            begin
                if (dcount >= DDEPTH)
                    return trap(sme_pkg::ERR_DATA);
                dstack[dcount] = it.first_operand;
                dcount++;
                nxt = {1'b0, ip} + 17'd2;
            end
            sme_pkg::OP_POP:
            begin
                if (dcount < 1)
                    return trap(sme_pkg::ERR_DATA);
                dcount--;
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_AND,
            sme_pkg::OP_OR, sme_pkg::OP_LT, sme_pkg::OP_EQ:
            begin
                if (dcount < 2)
                    return trap(sme_pkg::ERR_DATA);
                a = dstack[dcount - 2];
                b = dstack[dcount - 1];
                case (op)
                    sme_pkg::OP_ADD: r = a + b;
                    sme_pkg::OP_SUB: r = a - b;
                    sme_pkg::OP_MUL: r = a * b;
                    sme_pkg::OP_AND: r = a & b;
                    sme_pkg::OP_OR: r = a | b;
                    sme_pkg::OP_LT: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    default: r = (a == b) ? 32'd1 : 32'd0;
                endcase
                dstack[dcount - 2] = r;
                dcount--;
            end
            sme_pkg::OP_NOT:
            begin
                if (dcount < 1)
                    return trap(sme_pkg::ERR_DATA);
                dstack[dcount - 1] = (dstack[dcount - 1] == 0) ? 32'd1 : 32'd0;
            end
            sme_pkg::OP_JMP: nxt = {1'b0, it.first_operand[15:0]};
            sme_pkg::OP_JZ:
            begin
                if (dcount < 1)
                    return trap(sme_pkg::ERR_DATA);
                dcount--;
                nxt = (dstack[dcount] == 0) ? {1'b0, it.first_operand[15:0]}
                                            : {1'b0, ip} + 17'd2;
            end
            sme_pkg::OP_LOAD, sme_pkg::OP_STORE:
            begin
                if (fcount == 0)
                    return trap(sme_pkg::ERR_CALL);
                if (it.first_operand >= LPF)
                    return trap(sme_pkg::ERR_LOCAL);
                base = (fcount - 1) * LPF + it.first_operand;
                if (op == sme_pkg::OP_LOAD)
                begin
                    if (dcount >= DDEPTH)
                        return trap(sme_pkg::ERR_DATA);
                    dstack[dcount] = locals[base];
                    dcount++;
                end
                else
                begin
                    if (dcount < 1)
                        return trap(sme_pkg::ERR_DATA);
                    locals[base] = dstack[dcount - 1];
                    dcount--;
                end
                nxt = {1'b0, ip} + 17'd2;
            end
            sme_pkg::OP_CALL:
            begin
                if (fcount >= CDEPTH)
                    return trap(sme_pkg::ERR_CALL);
                if (it.arg_count > LPF)
                    return trap(sme_pkg::ERR_LOCAL);
                if (it.arg_count > dcount)
                    return trap(sme_pkg::ERR_DATA);
                rstack[fcount] = ip + 16'd4;
                base = fcount * LPF;
                for (int i = 0; i < it.arg_count; i++)
                    locals[base + i] = dstack[dcount - it.arg_count + i];
                dcount -= it.arg_count;
                fcount++;
                nxt = {1'b0, it.first_operand[15:0]};
            end
            sme_pkg::OP_RET:
            begin
                if (fcount == 0)
                    return trap(sme_pkg::ERR_CALL);
                fcount--;
                nxt = {1'b0, rstack[fcount]};
            end
            sme_pkg::OP_PRINT:
            begin
                if (dcount < 1)
                    return trap(sme_pkg::ERR_DATA);
                pv = 1'b1;
                val = dstack[dcount - 1];
                dcount--;
            end
            default:
            begin
                ip = nxt[15:0];
                stopped = 1'b1;
                return make_result(1'b0, 32'd0);
            end
        endcase
        ip = nxt[15:0];
        if (nxt >= {1'b0, length_reg})
            stopped = 1'b1;
        return make_result(pv, val);
    endfunction

    // The item on the ports stays until it is taken; a new one is only loaded once the
    // previous beat has gone or push was low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_results.push_back(execute_instr({action, op_code,
                                                          first_operand, arg_count}));
                beats_in++;
            end
            if (!(push && full))
            begin
                if (!send_hold && pending_instrs.size() > 0 &&
                    ($urandom_range(99) >= send_idle_pct))
                begin
                    instr_t it;
                    it = pending_instrs.pop_front();
                    push <= 1'b1;
                    action <= it.action;
                    op_code <= it.op_code;
                    first_operand <= it.first_operand;
                    arg_count <= it.arg_count;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                sme_pkg::res_t got;
                beats_out++;
                got = '{next_address, print_valid, print_value, halted,
                        sme_pkg::err_t'(error_code)};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    sme_pkg::res_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (got.print_valid)
                        prints_seen++;
                    if (got.error_code != sme_pkg::ERR_NONE)
                        errors_seen++;
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_r, got);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_START)
            start_reg = data[15:0];
        else
            length_reg = data[15:0];
    endtask

    task automatic add_instr(logic act, logic [4:0] op, logic [31:0] opnd, logic [4:0] na);
        pending_instrs.push_back({act, op, opnd, na});
    endtask

    task automatic drain();
        wait (pending_instrs.size() == 0 && !push);
        wait (expected_results.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // Random program fragments with a mostly valid stack discipline.
    task automatic add_random_run(int count);
        int depth;
        int frames;
        logic [4:0] op;
        logic [31:0] opnd;
        depth = 0;
        frames = 0;
        add_instr(1'b0, '0, $urandom, $urandom);
        for (int i = 0; i < count; i++)
        begin
            opnd = $urandom;
            case ($urandom_range(9))
                0: opnd = 32'h8000_0000;
                1: opnd = 32'h7fff_ffff;
                2: opnd = $urandom_range(3);
                default: ;
            endcase
            if ($urandom_range(19) == 0)
            begin
                add_instr($urandom_range(1), $urandom, $urandom, $urandom);
                continue;
            end
            if (depth < 2 || $urandom_range(3) == 0)
                op = sme_pkg::OP_PUSH;
            else
                op = $urandom_range(sme_pkg::OP_HALT - 1);
            if (op == sme_pkg::OP_JMP || op == sme_pkg::OP_JZ || op == sme_pkg::OP_CALL)
                opnd = $urandom_range(length_reg);
            if (op == sme_pkg::OP_LOAD || op == sme_pkg::OP_STORE)
                opnd = ($urandom_range(9) == 0) ? $urandom : $urandom_range(LPF - 1);
            if (op == sme_pkg::OP_CALL)
                frames++;
            if (op == sme_pkg::OP_RET && frames > 0)
                frames--;
            add_instr(1'b1, op, opnd,
                      (op == sme_pkg::OP_CALL) ? $urandom_range(depth < 3 ? depth : 3)
                                               : $urandom);
            case (op)
                sme_pkg::OP_PUSH, sme_pkg::OP_LOAD: depth++;
                sme_pkg::OP_NOT, sme_pkg::OP_JMP, sme_pkg::OP_RET, sme_pkg::OP_CALL: ;
                default: if (depth > 0) depth--;
            endcase
        end
    endtask

    initial
    begin
        send_idle_pct = 29;
        recv_idle_pct = 49;
        send_hold = 1'b0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        prints_seen = 0;
        errors_seen = 0;
        idle_cycles = 0;
        dcount = 0;
        fcount = 0;
        ip = '0;
        stopped = 1'b0;
        err_held = sme_pkg::ERR_NONE;
        start_reg = '0;
        length_reg = '0;
        for (int i = 0; i < DDEPTH; i++)
            dstack[i] = '0;
        for (int i = 0; i < CDEPTH; i++)
            rstack[i] = '0;
        for (int i = 0; i < CDEPTH * LPF; i++)
            locals[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty program: the machine halts at once.
        add_instr(1'b1, sme_pkg::OP_PUSH, 32'd5, 5'd0);
        add_instr(1'b0, sme_pkg::OP_PUSH, 32'd0, 5'd0);
        drain();

        reg_write(ADDR_START, 32'd10);
        reg_write(ADDR_LENGTH, 32'hffff);
        add_instr(1'b0, '0, '0, '0);
        add_instr(1'b1, sme_pkg::OP_POP, '0, '0);
        add_instr(1'b0, '0, '0, '0);
        add_instr(1'b1, sme_pkg::OP_PUSH, 32'h8000_0000, '0);
        add_instr(1'b1, sme_pkg::OP_PUSH, 32'h7fff_ffff, '0);
        add_instr(1'b1, sme_pkg::OP_LT, '0, '0);
        add_instr(1'b1, sme_pkg::OP_PUSH, 32'hffff_ffff, '0);
        add_instr(1'b1, sme_pkg::OP_MUL, '0, '0);
        add_instr(1'b1, sme_pkg::OP_NOT, '0, '0);
        add_instr(1'b1, sme_pkg::OP_PUSH, 32'd7, '0);
        add_instr(1'b1, sme_pkg::OP_CALL, 32'd100, 5'd2);
        add_instr(1'b1, sme_pkg::OP_LOAD, 32'd1, '0);
        add_instr(1'b1, sme_pkg::OP_STORE, 32'd15, '0);
        add_instr(1'b1, sme_pkg::OP_LOAD, 32'hffff_ffff, '0);
        add_instr(1'b0, '0, '0, '0);
        add_instr(1'b1, sme_pkg::OP_CALL, 32'd3, 5'd17);
        add_instr(1'b0, '0, '0, '0);
        add_instr(1'b1, sme_pkg::OP_RET, '0, '0);
        add_instr(1'b0, '0, '0, '0);
        add_instr(1'b1, 5'd31, '0, 5'd31);
        add_instr(1'b0, '0, '0, '0);
        add_instr(1'b1, sme_pkg::OP_JMP, 32'h0001_fffe, '0);
        add_instr(1'b1, sme_pkg::OP_PUSH, 32'd1, '0);
        add_instr(1'b1, sme_pkg::OP_PRINT, '0, '0);
        add_instr(1'b1, sme_pkg::OP_HALT, '0, '0);
        drain();

        // Stack overflow, call depth overflow, then a pause until all is idle.
        reg_write(ADDR_START, 32'd0);
        add_instr(1'b0, '0, '0, '0);
        for (int i = 0; i <= DDEPTH; i++)
            add_instr(1'b1, sme_pkg::OP_PUSH, $urandom, '0);
        add_instr(1'b0, '0, '0, '0);
        for (int i = 0; i <= CDEPTH; i++)
            add_instr(1'b1, sme_pkg::OP_CALL, 32'd0, '0);
        wait (pending_instrs.size() == 0 && !push);
        send_hold = 1'b1;
        wait (expected_results.size() == 0);
        send_hold = 1'b0;
        repeat (8) @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 49 : 0;
            recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 29 : 0;
            for (int k = 0; k < 4; k++)
            begin
                reg_write(ADDR_START, $urandom_range(20));
                reg_write(ADDR_LENGTH, (k == 3) ? 32'hffff : $urandom_range(40, 400));
                add_random_run(49);
                drain();
            end
        end

        $display("Ran %0d instruction beats, %0d results, %0d prints, %0d error results.",
                 beats_in, beats_out, prints_seen, errors_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
